// ===== src/assert_macros.svh =====
// Assertion helpers; each expects a clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ODO_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ODO_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/odo_pkg.sv =====
package odo_pkg;

  // Status codes on the result tuser
  localparam logic [1:0] ST_FIRST = 2'd0;
  localparam logic [1:0] ST_STEP  = 2'd1;
  localparam logic [1:0] ST_JUMP  = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] REG_MAX_TICK  = 3'd0;
  localparam logic [2:0] REG_DIST      = 3'd1;
  localparam logic [2:0] REG_GAIN      = 3'd2;
  localparam logic [2:0] REG_SIDE_OFS  = 3'd3;
  localparam logic [2:0] REG_START_X   = 3'd4;
  localparam logic [2:0] REG_START_Y   = 3'd5;
  localparam logic [2:0] REG_START_HDG = 3'd6;

  // Register reset values
  localparam logic [30:0] RST_MAX_TICK = 31'd50000;
  localparam logic [31:0] RST_DIST     = 32'd126494;
  localparam logic [47:0] RST_GAIN     = 48'd4569287885;
  localparam logic [31:0] RST_SIDE_OFS = 32'hFFFF_EFDF;  // -4129

  // Arithmetic constants
  localparam logic [63:0] RAD_Q40   = 64'd105414357;   // 2pi/65536 in Q40
  localparam logic [63:0] INV_GAIN  = 64'd2608131496;  // 1/K in Q32
  localparam logic [63:0] US_PER_S  = 64'd1000000;

  // Datapath widths
  localparam int XW = 52;          // CORDIC x/y
  localparam int ZW = 34;          // CORDIC residual angle
  localparam int NUM_W = 72;       // dividend (step * 1e6)
  localparam int ATAN_IDX_W = 5;
  localparam int ATAN_N = 24;

  localparam logic [31:0] ATAN_TAB [ATAN_N] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// ===== src/deadwheel_odometry_integrator.sv =====
// Three-wheel dead-wheel odometry integrator.
// Input stream (s_axis): one beat per encoder sample, absolute right/left/side
// counts and the microseconds since the previous sample. Output stream
// (m_axis): pose (x, y, 16-bit heading) and robot-frame speeds, Q16.16 but for the heading; tuser holds
// the status (first sample latched, integrated, jump rebased).
// Config: cfg_we/cfg_index/cfg_data, one register per cycle, no read-back.
// Writes to the start pose also load the pose until the first sample.
// Timing: one sample at a time; s_axis_tready is high only when idle.
// First-sample and jump beats go from S_CHECK straight to S_EMIT. An
// integrated sample runs eleven wide multiplies on the shared 32x32
// multiplier, the CORDIC rotation and three 32-step rate divisions.
// elapsed_us of 0 or 1 after the first sample is dropped with no beat.
// Output is a single register stage: a finished beat waits there while the
// receiver stalls, and the next sample can be accepted meanwhile; the block
// holds its own result only if that register is still full.
// Reset (rst, synchronous): registers to defaults, pose to the start pose,
// first-sample state, no beat pending.
module deadwheel_odometry_integrator #(
  parameter int CORDIC_STEPS = 16,
  parameter int COUNT_BITS   = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // right_count[31:0], left_count[63:32], side_count[95:64], elapsed_us[127:96]
  input  logic [127:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x[31:0], pos_y[63:32], heading_out[79:64], fwd_speed[111:80],
  // lat_speed[143:112], turn_rate[175:144]
  output logic [175:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0]   m_axis_tuser,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [47:0]  cfg_data
);

  `include "assert_macros.svh"

  localparam int  CB   = (COUNT_BITS < 32) ? COUNT_BITS : 32;
  localparam bit  ZEXT = (COUNT_BITS > 32);

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_MUL, S_MWAIT, S_CORD, S_CWAIT, S_DWAIT, S_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_RD, OP_LD, OP_SD, OP_ANG, OP_RAD, OP_LAT, OP_XS, OP_YS, OP_R0, OP_R1, OP_R2
  } op_t;

  state_t state;
  op_t    op;

  // configuration
  logic [30:0]        max_tick_delta;
  logic [31:0]        dist_per_tick;
  logic [47:0]        heading_gain;
  logic signed [31:0] side_offset, start_x, start_y;
  logic [15:0]        start_heading;

  // odometry state
  logic [31:0] prev_right, prev_left, prev_side;
  logic        started;
  logic [31:0] acc_x, acc_y;
  logic [15:0] acc_heading;
  logic [1:0]  status;

  // sample and step datapath
  logic [31:0]        in_r, in_l, in_s, in_e;
  logic signed [31:0] dr, dl, ds;
  logic signed [47:0] rd, ld, sd, dxr, dyr;
  logic signed [63:0] units;
  logic [31:0]        dang_mid, xs_w;
  logic [15:0]        dang_hi;
  logic signed [51:0] rad;
  logic [31:0]        fwd, lat, turn;

  logic signed [33:0] d_r, d_l, d_s;
  logic [33:0]        m_r, m_l, m_s;
  logic               jump;
  logic signed [48:0] sum_x, diff_rl;
  logic signed [63:0] op_a, op_b;
  logic signed [127:0] mul_p;
  logic [31:0]        div_q;
  logic signed [odo_pkg::XW-1:0] cor_x, cor_y;
  odo_pkg::unit_stat_t mul_stat, div_stat, cor_stat;
  logic               mul_start, div_start, cor_start, emit_load, is_rate;
  logic [31:0]        cor_angle;
  logic               units_ovf, lat_ovf, dyr_fit;
  logic signed [63:0] units_sat;
  logic signed [49:0] lat_t;
  logic signed [50:0] lat_sum;
  logic signed [47:0] dyr_c;

  function automatic logic signed [32:0] count_ext(input logic [31:0] v);
    logic [32:0] r;
    if (ZEXT) r = {1'b0, v};
    else r = {{(33 - CB){v[CB-1]}}, v[CB-1:0]};
    return signed'(r);
  endfunction

  // count deltas and jump check
  always_comb begin
    d_r  = 34'(count_ext(in_r)) - 34'(count_ext(prev_right));
    d_l  = 34'(count_ext(in_l)) - 34'(count_ext(prev_left));
    d_s  = 34'(count_ext(in_s)) - 34'(count_ext(prev_side));
    m_r  = d_r[33] ? 34'(-d_r) : d_r;
    m_l  = d_l[33] ? 34'(-d_l) : d_l;
    m_s  = d_s[33] ? 34'(-d_s) : d_s;
    jump = (m_r > {3'd0, max_tick_delta}) || (m_l > {3'd0, max_tick_delta}) ||
           (m_s > {3'd0, max_tick_delta});
  end

  assign sum_x   = 49'(rd) + 49'(ld);
  assign dxr     = sum_x[48:1];
  assign diff_rl = 49'(ld) - 49'(rd);
  assign cor_angle = {acc_heading, 16'd0} + dang_mid;

  // saturations on the wide products
  always_comb begin
    units_ovf = !((&mul_p[127:79]) || !(|mul_p[127:79]));
    units_sat = units_ovf ? (mul_p[127] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}})
                          : mul_p[79:16];
    lat_ovf   = !((&mul_p[127:65]) || !(|mul_p[127:65]));
    lat_t     = lat_ovf ? (mul_p[127] ? {1'b1, 49'd0} : {1'b0, {49{1'b1}}})
                        : mul_p[65:16];
    lat_sum   = 51'(sd) + 51'(lat_t);
    dyr_fit   = (&lat_sum[50:47]) || !(|lat_sum[50:47]);
    dyr_c     = dyr_fit ? lat_sum[47:0]
                        : (lat_sum[50] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}});
  end

  // shared multiplier operands
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (op)
      OP_RD:  begin op_a = 64'(-dr); op_b = 64'(dist_per_tick); end
      OP_LD:  begin op_a = 64'(-dl); op_b = 64'(dist_per_tick); end
      OP_SD:  begin op_a = 64'(-ds); op_b = 64'(dist_per_tick); end
      OP_ANG: begin op_a = 64'(diff_rl); op_b = 64'(heading_gain); end
      OP_RAD: begin op_a = units; op_b = odo_pkg::RAD_Q40; end
      OP_LAT: begin op_a = 64'(side_offset); op_b = 64'(rad); end
      OP_XS:  begin op_a = 64'(cor_x); op_b = odo_pkg::INV_GAIN; end
      OP_YS:  begin op_a = 64'(cor_y); op_b = odo_pkg::INV_GAIN; end
      OP_R0:  begin op_a = 64'(dxr); op_b = odo_pkg::US_PER_S; end
      OP_R1:  begin op_a = 64'(dyr); op_b = odo_pkg::US_PER_S; end
      OP_R2:  begin op_a = 64'(rad); op_b = odo_pkg::US_PER_S; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  assign is_rate   = (op == OP_R0) || (op == OP_R1) || (op == OP_R2);
  assign mul_start = (state == S_MUL);
  assign cor_start = (state == S_CORD);
  assign div_start = (state == S_MWAIT) && mul_stat.done && is_rate;
  assign emit_load = (state == S_EMIT) && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = (state == S_IDLE);

  odo_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a    (op_a),
    .b    (op_b),
    .stat (mul_stat),
    .p    (mul_p)
  );

  odo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk  (clk),
    .rst  (rst),
    .start(cor_start),
    .x0   (dxr),
    .y0   (dyr),
    .angle(cor_angle),
    .stat (cor_stat),
    .x    (cor_x),
    .y    (cor_y)
  );

  odo_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (mul_p[odo_pkg::NUM_W-1:0]),
    .den  (in_e),
    .stat (div_stat),
    .quo  (div_q)
  );

  // sequencer, configuration and pose
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      op             <= OP_RD;
      max_tick_delta <= odo_pkg::RST_MAX_TICK;
      dist_per_tick  <= odo_pkg::RST_DIST;
      heading_gain   <= odo_pkg::RST_GAIN;
      side_offset    <= odo_pkg::RST_SIDE_OFS;
      start_x        <= '0;
      start_y        <= '0;
      start_heading  <= '0;
      prev_right     <= '0;
      prev_left      <= '0;
      prev_side      <= '0;
      started        <= 1'b0;
      acc_x          <= '0;
      acc_y          <= '0;
      acc_heading    <= '0;
      status         <= odo_pkg::ST_FIRST;
      m_axis_tvalid  <= 1'b0;
      m_axis_tuser   <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) state <= S_CHECK;
        end
        S_CHECK: begin
          if (!started) begin
            prev_right <= in_r;
            prev_left  <= in_l;
            prev_side  <= in_s;
            started    <= 1'b1;
            status     <= odo_pkg::ST_FIRST;
            state      <= S_EMIT;
          end else if (in_e <= 32'd1) begin
            state <= S_IDLE;
          end else begin
            prev_right <= in_r;
            prev_left  <= in_l;
            prev_side  <= in_s;
            if (jump) begin
              status <= odo_pkg::ST_JUMP;
              state  <= S_EMIT;
            end else begin
              op    <= OP_RD;
              state <= S_MUL;
            end
          end
        end
        S_MUL: state <= S_MWAIT;
        S_MWAIT: begin
          if (mul_stat.done) begin
            unique case (op)
              OP_RD:  begin op <= OP_LD;  state <= S_MUL; end
              OP_LD:  begin op <= OP_SD;  state <= S_MUL; end
              OP_SD:  begin op <= OP_ANG; state <= S_MUL; end
              OP_ANG: begin op <= OP_RAD; state <= S_MUL; end
              OP_RAD: begin op <= OP_LAT; state <= S_MUL; end
              OP_LAT: state <= S_CORD;
              OP_XS:  begin op <= OP_YS;  state <= S_MUL; end
              OP_YS: begin
                acc_x       <= acc_x + xs_w;
                acc_y       <= acc_y + mul_p[63:32];
                acc_heading <= acc_heading + dang_hi;
                op          <= OP_R0;
                state       <= S_MUL;
              end
              OP_R0, OP_R1, OP_R2: state <= S_DWAIT;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_CORD: state <= S_CWAIT;
        S_CWAIT: begin
          if (cor_stat.done) begin
            op    <= OP_XS;
            state <= S_MUL;
          end
        end
        S_DWAIT: begin
          if (div_stat.done) begin
            priority case (op)
              OP_R0: begin op <= OP_R1; state <= S_MUL; end
              OP_R1: begin op <= OP_R2; state <= S_MUL; end
              default: begin
                status <= odo_pkg::ST_STEP;
                state  <= S_EMIT;
              end
            endcase
          end
        end
        S_EMIT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser  <= status;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      // config writes must arrive only while idle; the block itself does not enforce this
      if (cfg_we) begin
        unique case (cfg_index)
          odo_pkg::REG_MAX_TICK: max_tick_delta <= cfg_data[30:0];
          odo_pkg::REG_DIST:     dist_per_tick  <= cfg_data[31:0];
          odo_pkg::REG_GAIN:     heading_gain   <= cfg_data;
          odo_pkg::REG_SIDE_OFS: side_offset    <= cfg_data[31:0];
          odo_pkg::REG_START_X: begin
            start_x <= cfg_data[31:0];
            if (!started) acc_x <= cfg_data[31:0];
          end
          odo_pkg::REG_START_Y: begin
            start_y <= cfg_data[31:0];
            if (!started) acc_y <= cfg_data[31:0];
          end
          odo_pkg::REG_START_HDG: begin
            start_heading <= cfg_data[15:0];
            if (!started) acc_heading <= cfg_data[15:0];
          end
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_axis_tvalid) begin
      in_r <= s_axis_tdata[31:0];
      in_l <= s_axis_tdata[63:32];
      in_s <= s_axis_tdata[95:64];
      in_e <= s_axis_tdata[127:96];
    end
    if (state == S_CHECK) begin
      dr   <= d_r[31:0];
      dl   <= d_l[31:0];
      ds   <= d_s[31:0];
      fwd  <= '0;
      lat  <= '0;
      turn <= '0;
    end
    if (state == S_MWAIT && mul_stat.done) begin
      unique case (op)
        OP_RD:  rd <= mul_p[63:16];
        OP_LD:  ld <= mul_p[63:16];
        OP_SD:  sd <= mul_p[63:16];
        OP_ANG: begin
          units    <= units_sat;
          dang_mid <= mul_p[48:17];
          dang_hi  <= mul_p[47:32];
        end
        OP_RAD: rad  <= mul_p[91:40];
        OP_LAT: dyr  <= dyr_c;
        OP_XS:  xs_w <= mul_p[63:32];
        default: ;
      endcase
    end
    if (state == S_DWAIT && div_stat.done) begin
      priority case (op)
        OP_R0: fwd <= div_q;
        OP_R1: lat <= div_q;
        default: turn <= div_q;
      endcase
    end
    if (emit_load) begin
      m_axis_tdata <= {turn, lat, fwd, acc_heading, acc_y, acc_x};
    end
  end

  `ODO_ASSERT_IMP(a_accept_units_idle, s_axis_tvalid && s_axis_tready, !(mul_stat.busy || div_stat.busy || cor_stat.busy), "sample accepted while a unit is busy")
  `ODO_ASSERT_IMP(a_mul_done_in_wait, mul_stat.done, state == S_MWAIT, "multiplier finished outside its wait state")
  `ODO_ASSERT_IMP(a_div_done_in_wait, div_stat.done, state == S_DWAIT, "divider finished outside its wait state")
  `ODO_ASSERT_NXT(a_emit_holds, state == S_EMIT && m_axis_tvalid && !m_axis_tready, state == S_EMIT, "result left emit while output full")

endmodule

// ===== src/odo_mul.sv =====
// 64x64 signed multiply on one 32x32 multiplier, four partial products.
module odo_mul (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [63:0]   a,
  input  logic signed [63:0]   b,
  output odo_pkg::unit_stat_t  stat,
  output logic signed [127:0]  p
);

  logic [63:0]  ma, mb, pp;
  logic [127:0] acc;
  logic         neg;
  logic [2:0]   cnt;
  logic [1:0]   psh;
  logic [31:0]  ah, bh;

  assign ah = cnt[1] ? ma[63:32] : ma[31:0];
  assign bh = cnt[0] ? mb[63:32] : mb[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= '0;
      end else if (stat.busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd5) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ma  <= a[63] ? 64'(-a) : a;
      mb  <= b[63] ? 64'(-b) : b;
      neg <= a[63] ^ b[63];
      acc <= '0;
    end else if (stat.busy) begin
      if (cnt < 3'd4) begin
        pp  <= ah * bh;
        psh <= {1'b0, cnt[1]} + {1'b0, cnt[0]};
      end
      if (cnt != 3'd0 && cnt != 3'd5) begin
        acc <= acc + ({64'd0, pp} << {psh, 5'd0});
      end
      if (cnt == 3'd5) begin
        p <= neg ? signed'(~acc + 128'd1) : signed'(acc);
      end
    end
  end

endmodule

// ===== src/odo_div.sv =====
// Rate divider: |num| / den, truncated, signed result saturated to 32 bits.
// One quotient bit a cycle.
module odo_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [odo_pkg::NUM_W-1:0]   num,
  input  logic [31:0]                        den,
  output odo_pkg::unit_stat_t                stat,
  output logic [31:0]                        quo
);

  logic [odo_pkg::NUM_W-1:0] mag;
  logic [31:0] rem, sh, q, den_r;
  logic [32:0] r2;
  logic        ge, neg;
  logic [5:0]  cnt;

  assign mag = num[odo_pkg::NUM_W-1] ? odo_pkg::NUM_W'(-num) : num;
  assign r2  = {rem, sh[31]};
  assign ge  = r2 >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        cnt <= '0;
        // quotient of 2^32 or more: saturate at once
        if (mag[odo_pkg::NUM_W-1:32] >= (odo_pkg::NUM_W-32)'(den)) begin
          stat.done <= 1'b1;
        end else begin
          stat.busy <= 1'b1;
        end
      end else if (stat.busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd32) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg   <= num[odo_pkg::NUM_W-1];
      rem   <= mag[63:32];
      sh    <= mag[31:0];
      den_r <= den;
      q     <= '0;
      if (mag[odo_pkg::NUM_W-1:32] >= (odo_pkg::NUM_W-32)'(den)) begin
        quo <= num[odo_pkg::NUM_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end
    end else if (stat.busy) begin
      if (cnt < 6'd32) begin
        rem <= ge ? 32'(r2 - {1'b0, den_r}) : r2[31:0];
        q   <= {q[30:0], ge};
        sh  <= {sh[30:0], 1'b0};
      end else if (neg) begin
        quo <= q[31] ? 32'h8000_0000 : (~q + 32'd1);
      end else begin
        quo <= q[31] ? 32'h7FFF_FFFF : q;
      end
    end
  end

endmodule

// ===== src/odo_cordic.sv =====
// Rotation CORDIC: quarter-turn prerotation, then one micro-rotation a cycle.
// Output carries the CORDIC gain.
module odo_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [47:0]                x0,
  input  logic signed [47:0]                y0,
  input  logic [31:0]                       angle,
  output odo_pkg::unit_stat_t               stat,
  output logic signed [odo_pkg::XW-1:0]     x,
  output logic signed [odo_pkg::XW-1:0]     y
);

  localparam logic [odo_pkg::ATAN_IDX_W-1:0] LAST = odo_pkg::ATAN_IDX_W'(CORDIC_STEPS - 1);

  logic signed [odo_pkg::ZW-1:0]  z;
  logic [odo_pkg::ATAN_IDX_W-1:0] i;
  logic signed [odo_pkg::XW-1:0]  xe, ye, xs, ys;
  logic [31:0] qsum, res;
  logic [1:0]  qd;
  logic [odo_pkg::ZW-1:0] at;

  assign xe   = odo_pkg::XW'(x0);
  assign ye   = odo_pkg::XW'(y0);
  assign qsum = angle + 32'h2000_0000;
  assign qd   = qsum[31:30];
  assign res  = angle - {qd, 30'd0};
  assign xs   = x >>> i;
  assign ys   = y >>> i;
  assign at   = odo_pkg::ZW'(odo_pkg::ATAN_TAB[i]);

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      i    <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        i         <= '0;
      end else if (stat.busy) begin
        i <= i + 1'b1;
        if (i == LAST) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      z <= odo_pkg::ZW'(signed'(res));
      unique case (qd)
        2'd0: begin x <= xe;  y <= ye;  end
        2'd1: begin x <= -ye; y <= xe;  end
        2'd2: begin x <= -xe; y <= -ye; end
        2'd3: begin x <= ye;  y <= -xe; end
        default: begin x <= xe; y <= ye; end
      endcase
    end else if (stat.busy) begin
      if (!z[odo_pkg::ZW-1]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - signed'(at);
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + signed'(at);
      end
    end
  end

endmodule
